@@ hdl/apmd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and tables for the angle PID motor drive.
package apmd_pkg;

  // sample period in ms; must divide 4096000
  localparam int SAMPLE_MS = 10;
  localparam int OUT_LIMIT = 1000;

  localparam int ANG_W     = 13;
  localparam int ERR_W     = 13;
  localparam int DE_W      = ERR_W + 1;
  localparam int REF_FRAC  = 13;
  localparam int REF_W     = ANG_W + REF_FRAC;
  localparam int HALF_TURN = 2880;
  localparam int FULL_TURN = 5760;
  localparam int GAIN_W    = 16;
  localparam int SPD_W     = 7;
  localparam int SB_W      = 12;
  localparam int LVL_W     = 10;
  localparam int DIR_W     = 2;
  localparam int CO_W      = 11;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam int LIMIT = (OUT_LIMIT > 1023) ? 1023 : OUT_LIMIT;

  // integral: degree-seconds, 16 fraction bits, clamped to +-500
  localparam int INT_CLAMP = 500 * 65536;
  localparam int INT_W     = $clog2(INT_CLAMP) + 1;
  localparam int I_LO_W    = 16;

  // integral step round(|e|*S*4096/1000) = floor((|e|*S*1024 + 125) / 250)
  localparam longint XMAX    = longint'(HALF_TURN) * SAMPLE_MS * 1024 + 125;
  localparam int     X_W     = $clog2(XMAX + 1);
  localparam int     QDIV_SH = X_W + 8;
  localparam longint QDIV_M  = ((longint'(1) << QDIV_SH) + 249) / 250;
  localparam int     M_W     = $clog2(QDIV_M + 1);
  localparam longint QMAX    = (longint'(HALF_TURN) * SAMPLE_MS * 4096 + 500) / 1000;
  localparam int     Q_W     = $clog2(QMAX + 1);

  // output sum, already divided by SAMPLE_MS; scaled by 2^24
  localparam int KD_SCALE = 4096000 / SAMPLE_MS;
  localparam int KD_W     = $clog2(KD_SCALE + 1);
  localparam int PK_SH    = 12;
  localparam int OUT_SH   = 24;
  localparam int PK_W     = GAIN_W + 1 + ERR_W;
  localparam int DK_W     = GAIN_W + 1 + DE_W;
  localparam int DKS_W    = DK_W + KD_W + 1;
  localparam int IPL_W    = GAIN_W + I_LO_W;
  localparam int IPH_W    = GAIN_W + 1 + INT_W - I_LO_W;
  localparam int NUM_W    = DKS_W + 2;
  localparam int OF_W     = NUM_W - OUT_SH;

  // ramp increment per tick, 2^-17 degree units
  localparam longint INC_MAX =
    ((1300 + 482 * (longint'(2) ** SPD_W - 1)) * 131072 + 4950) / 9900;
  localparam int INC_W = $clog2(INC_MAX + 1);

  typedef logic [INC_W-1:0] inc_tbl_t [2**SPD_W];

  function automatic inc_tbl_t ramp_inc_tbl();
    inc_tbl_t t;
    longint   v;
    for (int i = 0; i < 2**SPD_W; i++) begin
      v    = ((1300 + 482 * longint'(i)) * 131072 + 4950) / 9900;
      t[i] = INC_W'(v);
    end
    return t;
  endfunction

  localparam inc_tbl_t RAMP_INC = ramp_inc_tbl();

  // register reset values
  localparam logic              RST_RAMP_MODE = 1'b0;
  localparam logic [ANG_W-1:0]  RST_SETPOINT  = ANG_W'(1440);
  localparam logic [SPD_W-1:0]  RST_SPEED     = '0;
  localparam logic [GAIN_W-1:0] RST_KP        = GAIN_W'(1024);
  localparam logic [GAIN_W-1:0] RST_KI        = GAIN_W'(13);
  localparam logic [GAIN_W-1:0] RST_KD        = GAIN_W'(26);
  localparam logic [SB_W-1:0]   RST_STOP_BAND = SB_W'(16);
  localparam logic [LVL_W-1:0]  RST_MIN_DRIVE = LVL_W'(80);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_MODE  = CFG_IDX_W'(0),
    REG_SETPOINT   = CFG_IDX_W'(1),
    REG_RAMP_SPEED = CFG_IDX_W'(2),
    REG_KP_GAIN    = CFG_IDX_W'(3),
    REG_KI_GAIN    = CFG_IDX_W'(4),
    REG_KD_GAIN    = CFG_IDX_W'(5),
    REG_STOP_BAND  = CFG_IDX_W'(6),
    REG_MIN_DRIVE  = CFG_IDX_W'(7)
  } cfg_reg_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_BRAKE = DIR_W'(0),
    DIR_CW    = DIR_W'(1),
    DIR_CCW   = DIR_W'(2)
  } dir_t;

  typedef struct packed {
    logic             ramp_mode;
    logic [ANG_W-1:0] setpoint;
    logic [SPD_W-1:0] ramp_speed;
  } ref_cfg_t;

endpackage

@@ hdl/apmd_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for angle samples and drive results.
interface apmd_in_if;
  logic                      valid;
  logic                      ready;
  logic [apmd_pkg::ANG_W-1:0] angle;
  logic                      enable;

  modport source (output valid, angle, enable, input ready);
  modport sink   (input valid, angle, enable, output ready);
endinterface

interface apmd_out_if;
  logic                             valid;
  logic                             ready;
  logic [apmd_pkg::LVL_W-1:0]       drive_level;
  logic [apmd_pkg::DIR_W-1:0]       direction;
  logic signed [apmd_pkg::CO_W-1:0] control_out;

  modport source (output valid, drive_level, direction, control_out, input ready);
  modport sink   (input valid, drive_level, direction, control_out, output ready);
endinterface

@@ hdl/angle_pid_motor_drive.sv @@
`timescale 1ns / 1ps
// Each accepted input word gives one result word on out_word, registered in every stage below.
// Throughput: one word per cycle; the eight register stages (input, reference/error,
// |e| scaling/derivative, integral step and P/D products, integral update, I partial
// products, sum, round/clamp/drive) each hold one word and stall only on out_word.ready.
// Reset (rst_n low, synchronous): pipeline empty, registers to defaults,
// reference, integral, previous error and held drive cleared.
module angle_pid_motor_drive (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [apmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apmd_pkg::CFG_DATA_W-1:0]     cfg_data,
  apmd_in_if.sink                             in_word,
  apmd_out_if.source                          out_word
);

  localparam int NST = 8;

  localparam logic signed [apmd_pkg::INT_W+1:0] ICL_P =
    (apmd_pkg::INT_W + 2)'(apmd_pkg::INT_CLAMP);
  localparam logic signed [apmd_pkg::OF_W-1:0] LIM_P = apmd_pkg::OF_W'(apmd_pkg::LIMIT);
  localparam logic signed [apmd_pkg::NUM_W-1:0] RND_HALF =
    apmd_pkg::NUM_W'(longint'(1) << (apmd_pkg::OUT_SH - 1));

  // configuration
  logic                          ramp_mode_r;
  logic [apmd_pkg::ANG_W-1:0]    setpoint_r;
  logic [apmd_pkg::SPD_W-1:0]    ramp_speed_r;
  logic [apmd_pkg::GAIN_W-1:0]   kp_r, ki_r, kd_r;
  logic [apmd_pkg::SB_W-1:0]     stop_band_r;
  logic [apmd_pkg::LVL_W-1:0]    min_drive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_mode_r  <= apmd_pkg::RST_RAMP_MODE;
      setpoint_r   <= apmd_pkg::RST_SETPOINT;
      ramp_speed_r <= apmd_pkg::RST_SPEED;
      kp_r         <= apmd_pkg::RST_KP;
      ki_r         <= apmd_pkg::RST_KI;
      kd_r         <= apmd_pkg::RST_KD;
      stop_band_r  <= apmd_pkg::RST_STOP_BAND;
      min_drive_r  <= apmd_pkg::RST_MIN_DRIVE;
    end else if (cfg_we) begin
      unique case (apmd_pkg::cfg_reg_t'(cfg_index))
        apmd_pkg::REG_RAMP_MODE:  ramp_mode_r  <= cfg_data[0];
        apmd_pkg::REG_SETPOINT:   setpoint_r   <= cfg_data[apmd_pkg::ANG_W-1:0];
        apmd_pkg::REG_RAMP_SPEED: ramp_speed_r <= cfg_data[apmd_pkg::SPD_W-1:0];
        apmd_pkg::REG_KP_GAIN:    kp_r         <= cfg_data[apmd_pkg::GAIN_W-1:0];
        apmd_pkg::REG_KI_GAIN:    ki_r         <= cfg_data[apmd_pkg::GAIN_W-1:0];
        apmd_pkg::REG_KD_GAIN:    kd_r         <= cfg_data[apmd_pkg::GAIN_W-1:0];
        apmd_pkg::REG_STOP_BAND:  stop_band_r  <= cfg_data[apmd_pkg::SB_W-1:0];
        apmd_pkg::REG_MIN_DRIVE:  min_drive_r  <= cfg_data[apmd_pkg::LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic [NST-1:0] vld_r, rdy, mv;

  always_comb begin
    rdy[NST-1] = !vld_r[NST-1] || out_word.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    mv[0] = in_word.valid && rdy[0];
    for (int k = 1; k < NST; k++) begin
      mv[k] = vld_r[k-1] && rdy[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_word.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_word.ready = rdy[0];

  // stage 1: input register
  logic [apmd_pkg::ANG_W-1:0] s1_angle_r;
  logic                       s1_en_r;

  always_ff @(posedge clk) begin
    if (mv[0]) begin
      s1_angle_r <= in_word.angle;
      s1_en_r    <= in_word.enable;
    end
  end

  // stage 2: reference and error
  apmd_pkg::ref_cfg_t               ref_cfg;
  logic signed [apmd_pkg::ERR_W-1:0] err_c;
  logic signed [apmd_pkg::ERR_W-1:0] s2_err_r;
  logic                              s2_en_r;

  assign ref_cfg = '{ramp_mode: ramp_mode_r, setpoint: setpoint_r,
                     ramp_speed: ramp_speed_r};

  apmd_ref_unit u_ref (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (mv[1] && s1_en_r),
    .cfg   (ref_cfg),
    .angle (s1_angle_r),
    .err   (err_c)
  );

  always_ff @(posedge clk) begin
    if (mv[1]) begin
      s2_err_r <= err_c;
      s2_en_r  <= s1_en_r;
    end
  end

  // stage 3: |e| scaling, stop band, derivative difference
  logic signed [apmd_pkg::ERR_W-1:0] prev_err_r;
  logic [apmd_pkg::ERR_W-1:0]        abs_e;
  logic [apmd_pkg::X_W-1:0]          x_c, s3_x_r;
  logic signed [apmd_pkg::DE_W-1:0]  de_c, s3_de_r;
  logic signed [apmd_pkg::ERR_W-1:0] s3_err_r;
  logic                              s3_neg_r, s3_band_r, s3_en_r;

  always_comb begin
    abs_e = s2_err_r[apmd_pkg::ERR_W-1] ? apmd_pkg::ERR_W'(-s2_err_r) : s2_err_r;
    x_c   = apmd_pkg::X_W'(longint'(abs_e) * apmd_pkg::SAMPLE_MS * 1024 + 125);
    de_c  = $signed({s2_err_r[apmd_pkg::ERR_W-1], s2_err_r}) -
            $signed({prev_err_r[apmd_pkg::ERR_W-1], prev_err_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
    end else if (mv[2] && s2_en_r) begin
      prev_err_r <= s2_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mv[2]) begin
      s3_x_r    <= x_c;
      s3_de_r   <= de_c;
      s3_err_r  <= s2_err_r;
      s3_neg_r  <= s2_err_r[apmd_pkg::ERR_W-1];
      s3_band_r <= abs_e <= {1'b0, stop_band_r};
      s3_en_r   <= s2_en_r;
    end
  end

  // stage 4: integral step by reciprocal, P and D products
  logic [apmd_pkg::X_W+apmd_pkg::M_W-1:0] qprod;
  logic signed [apmd_pkg::PK_W-1:0]       pk_c, s4_pk_r;
  logic signed [apmd_pkg::DK_W-1:0]       dk_c, s4_dk_r;
  logic [apmd_pkg::Q_W-1:0]               s4_q_r;
  logic                                   s4_neg_r, s4_band_r, s4_en_r;

  always_comb begin
    qprod = {{apmd_pkg::M_W{1'b0}}, s3_x_r} *
            (apmd_pkg::X_W + apmd_pkg::M_W)'(apmd_pkg::QDIV_M);
    pk_c  = $signed({1'b0, kp_r}) * s3_err_r;
    dk_c  = $signed({1'b0, kd_r}) * s3_de_r;
  end

  always_ff @(posedge clk) begin
    if (mv[3]) begin
      s4_q_r    <= qprod[apmd_pkg::QDIV_SH +: apmd_pkg::Q_W];
      s4_pk_r   <= pk_c;
      s4_dk_r   <= dk_c;
      s4_neg_r  <= s3_neg_r;
      s4_band_r <= s3_band_r;
      s4_en_r   <= s3_en_r;
    end
  end

  // stage 5: integral accumulate and clamp
  logic signed [apmd_pkg::INT_W-1:0] integ_r, i_cl, s5_i_r;
  logic signed [apmd_pkg::INT_W+1:0] step, isum, q_ext;
  logic signed [apmd_pkg::PK_W-1:0]  s5_pk_r;
  logic signed [apmd_pkg::DK_W-1:0]  s5_dk_r;
  logic                              s5_band_r, s5_en_r;

  always_comb begin
    q_ext = $signed({{(apmd_pkg::INT_W + 2 - apmd_pkg::Q_W){1'b0}}, s4_q_r});
    step  = s4_neg_r ? -q_ext : q_ext;
    isum  = $signed({{2{integ_r[apmd_pkg::INT_W-1]}}, integ_r}) + step;
    if (isum > ICL_P) begin
      i_cl = apmd_pkg::INT_W'(ICL_P);
    end else if (isum < -ICL_P) begin
      i_cl = apmd_pkg::INT_W'(-ICL_P);
    end else begin
      i_cl = isum[apmd_pkg::INT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (mv[4] && s4_en_r) begin
      integ_r <= s4_band_r ? '0 : i_cl;
    end
  end

  always_ff @(posedge clk) begin
    if (mv[4]) begin
      s5_i_r    <= i_cl;
      s5_pk_r   <= s4_pk_r;
      s5_dk_r   <= s4_dk_r;
      s5_band_r <= s4_band_r;
      s5_en_r   <= s4_en_r;
    end
  end

  // stage 6: I partial products, D scaling
  logic [apmd_pkg::IPL_W-1:0]        ipl_c, s6_ipl_r;
  logic signed [apmd_pkg::IPH_W-1:0] iph_c, s6_iph_r;
  logic signed [apmd_pkg::DKS_W-1:0] dks_c, s6_dks_r;
  logic signed [apmd_pkg::PK_W-1:0]  s6_pk_r;
  logic                              s6_band_r, s6_en_r;

  always_comb begin
    ipl_c = s5_i_r[apmd_pkg::I_LO_W-1:0] * ki_r;
    iph_c = $signed({1'b0, ki_r}) * $signed(s5_i_r[apmd_pkg::INT_W-1:apmd_pkg::I_LO_W]);
    dks_c = s5_dk_r * $signed({1'b0, apmd_pkg::KD_W'(apmd_pkg::KD_SCALE)});
  end

  always_ff @(posedge clk) begin
    if (mv[5]) begin
      s6_ipl_r  <= ipl_c;
      s6_iph_r  <= iph_c;
      s6_dks_r  <= dks_c;
      s6_pk_r   <= s5_pk_r;
      s6_band_r <= s5_band_r;
      s6_en_r   <= s5_en_r;
    end
  end

  // stage 7: sum of terms
  logic signed [apmd_pkg::NUM_W-1:0] t_pk, t_ih, t_il, t_dk, num_c, s7_num_r;
  logic                              s7_band_r, s7_en_r;

  always_comb begin
    t_pk  = apmd_pkg::NUM_W'(s6_pk_r) <<< apmd_pkg::PK_SH;
    t_ih  = apmd_pkg::NUM_W'(s6_iph_r) <<< apmd_pkg::I_LO_W;
    t_il  = $signed({{(apmd_pkg::NUM_W - apmd_pkg::IPL_W){1'b0}}, s6_ipl_r});
    t_dk  = apmd_pkg::NUM_W'(s6_dks_r);
    num_c = t_pk + t_ih + t_il + t_dk;
  end

  always_ff @(posedge clk) begin
    if (mv[6]) begin
      s7_num_r  <= num_c;
      s7_band_r <= s6_band_r;
      s7_en_r   <= s6_en_r;
    end
  end

  // stage 8: round, clamp, minimum drive; held drive is the result word
  logic signed [apmd_pkg::NUM_W-1:0] bias, rnd;
  logic signed [apmd_pkg::OF_W-1:0]  of_c;
  logic signed [apmd_pkg::CO_W-1:0]  o_cl, o_fin, md_s;
  logic [apmd_pkg::LVL_W-1:0]        cl_mag, fin_mag;
  logic [apmd_pkg::LVL_W-1:0]        held_lvl_r, held_lvl_nxt;
  apmd_pkg::dir_t                    held_dir_r, held_dir_nxt;
  logic signed [apmd_pkg::CO_W-1:0]  last_out_r, last_out_nxt;

  always_comb begin
    // ties away from zero: negative sums round with half minus one
    bias = s7_num_r[apmd_pkg::NUM_W-1] ? RND_HALF - 1 : RND_HALF;
    rnd  = s7_num_r + bias;
    of_c = rnd[apmd_pkg::NUM_W-1:apmd_pkg::OUT_SH];
    if (of_c > LIM_P) begin
      o_cl = apmd_pkg::CO_W'(LIM_P);
    end else if (of_c < -LIM_P) begin
      o_cl = apmd_pkg::CO_W'(-LIM_P);
    end else begin
      o_cl = of_c[apmd_pkg::CO_W-1:0];
    end
    cl_mag = o_cl[apmd_pkg::CO_W-1] ? apmd_pkg::LVL_W'(-o_cl) : o_cl[apmd_pkg::LVL_W-1:0];
    md_s   = $signed({1'b0, min_drive_r});
    if (s7_band_r) begin
      o_fin = '0;
    end else if (cl_mag < min_drive_r) begin
      o_fin = (o_cl > 0) ? md_s : -md_s;
    end else begin
      o_fin = o_cl;
    end
    fin_mag = o_fin[apmd_pkg::CO_W-1] ? apmd_pkg::LVL_W'(-o_fin) : o_fin[apmd_pkg::LVL_W-1:0];

    held_lvl_nxt = held_lvl_r;
    held_dir_nxt = held_dir_r;
    last_out_nxt = last_out_r;
    if (!s7_en_r) begin
      held_lvl_nxt = '0;
    end else begin
      if (s7_band_r) begin
        held_dir_nxt = apmd_pkg::DIR_BRAKE;
      end
      if (o_fin > 0) begin
        held_dir_nxt = apmd_pkg::DIR_CW;
        held_lvl_nxt = fin_mag;
      end else if (o_fin < 0) begin
        held_dir_nxt = apmd_pkg::DIR_CCW;
        held_lvl_nxt = fin_mag;
      end
      last_out_nxt = o_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_lvl_r <= '0;
      held_dir_r <= apmd_pkg::DIR_BRAKE;
      last_out_r <= '0;
    end else if (mv[7]) begin
      held_lvl_r <= held_lvl_nxt;
      held_dir_r <= held_dir_nxt;
      last_out_r <= last_out_nxt;
    end
  end

  assign out_word.valid       = vld_r[NST-1];
  assign out_word.drive_level = held_lvl_r;
  assign out_word.direction   = held_dir_r;
  assign out_word.control_out = last_out_r;

endmodule

@@ hdl/apmd_ref_unit.sv @@
`timescale 1ns / 1ps
// Reference generator (step or ramp) and wrapped angle error.
module apmd_ref_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              upd,
  input  apmd_pkg::ref_cfg_t                cfg,
  input  logic [apmd_pkg::ANG_W-1:0]        angle,
  output logic signed [apmd_pkg::ERR_W-1:0] err
);

  localparam int DW = apmd_pkg::ERR_W + 2;
  localparam logic signed [DW-1:0] HALF_D = DW'(apmd_pkg::HALF_TURN);
  localparam logic signed [DW-1:0] FULL_D = DW'(apmd_pkg::FULL_TURN);

  logic [apmd_pkg::REF_W-1:0] ref_r, ref_nxt, sp_fx;
  logic [apmd_pkg::REF_W:0]   ramp_sum;
  logic [apmd_pkg::ANG_W-1:0] sp;
  logic signed [DW-1:0]       diff, wrapped;

  always_comb begin
    sp = (cfg.setpoint > apmd_pkg::ANG_W'(apmd_pkg::FULL_TURN)) ?
         apmd_pkg::ANG_W'(apmd_pkg::FULL_TURN) : cfg.setpoint;
    sp_fx = {sp, {apmd_pkg::REF_FRAC{1'b0}}};
    ramp_sum = {1'b0, ref_r} +
               {{(apmd_pkg::REF_W + 1 - apmd_pkg::INC_W){1'b0}},
                apmd_pkg::RAMP_INC[cfg.ramp_speed]};
    if (!cfg.ramp_mode) begin
      ref_nxt = sp_fx;
    end else if (ramp_sum > {1'b0, sp_fx}) begin
      ref_nxt = sp_fx;
    end else begin
      ref_nxt = ramp_sum[apmd_pkg::REF_W-1:0];
    end
    diff = $signed({2'b00, ref_nxt[apmd_pkg::REF_W-1:apmd_pkg::REF_FRAC]}) -
           $signed({2'b00, angle});
    if (diff > HALF_D) begin
      wrapped = diff - FULL_D;
    end else if (diff < -HALF_D) begin
      wrapped = diff + FULL_D;
    end else begin
      wrapped = diff;
    end
    err = wrapped[apmd_pkg::ERR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
    end else if (upd) begin
      ref_r <= ref_nxt;
    end
  end

endmodule

@@ tb/sv/angle_pid_motor_drive_checker.sv @@
`timescale 1ns / 1ps
// Drive checker: predicts each result word of the angle PID drive and compares it.
module angle_pid_motor_drive_checker
  import apmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  apmd_in_if                    in_word,
  apmd_out_if                   out_word,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [LVL_W-1:0]       level;
    dir_t                   dir;
    logic signed [CO_W-1:0] co;
  } drive_word_t;

  drive_word_t drive_due[$];
  int fails = 0;
  int waiting = 0;
  int words_out = 0;

  // register shadow
  logic              ramp_on;
  logic [ANG_W-1:0]  sp;
  logic [SPD_W-1:0]  spd;
  logic [GAIN_W-1:0] kp, ki, kd;
  logic [SB_W-1:0]   sb;
  logic [LVL_W-1:0]  md;

  // controller state
  logic [REF_W-1:0] ref_fx;
  longint           integ;
  int               prev_err;
  logic [LVL_W-1:0] lvl;
  dir_t             dir;
  int               last_co;

  assign fail_count = fails;
  assign pending    = waiting;

  task automatic report_mismatch(input string msg);
    $display("mismatch at result word %0d: %s", words_out, msg);
    fails++;
  endtask

  function automatic longint div_round(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic drive_word_t advance_drive(logic [ANG_W-1:0] ang, logic en);
    drive_word_t w;
    longint      sp_fx;
    longint      r;
    longint      num;
    longint      o;
    int          err;
    if (!en) begin
      lvl = '0;
    end else begin
      sp_fx = longint'((sp > FULL_TURN) ? FULL_TURN : sp) << REF_FRAC;
      if (!ramp_on) begin
        ref_fx = REF_W'(sp_fx);
      end else begin
        r = longint'(ref_fx) + ((1300 + 482 * longint'(spd)) * 131072 + 4950) / 9900;
        if (r > sp_fx) r = sp_fx;
        ref_fx = REF_W'(r);
      end

      err = int'(ref_fx >> REF_FRAC) - int'(ang);
      if (err > HALF_TURN) err -= FULL_TURN;
      else if (err < -HALF_TURN) err += FULL_TURN;

      integ += div_round(longint'(err) * SAMPLE_MS * 4096, 1000);
      if (integ > INT_CLAMP) integ = INT_CLAMP;
      if (integ < -INT_CLAMP) integ = -INT_CLAMP;

      num = longint'(kp) * longint'(err) * 4096 * SAMPLE_MS
          + longint'(ki) * integ * SAMPLE_MS
          + longint'(kd) * longint'(err - prev_err) * 4096000;
      o = div_round(num, longint'(16777216) * SAMPLE_MS);
      prev_err = err;

      if (o > LIMIT) o = LIMIT;
      if (o < -LIMIT) o = -LIMIT;

      if (((err < 0) ? -err : err) > int'(sb)) begin
        if (((o < 0) ? -o : o) < longint'(md)) o = (o > 0) ? longint'(md) : -longint'(md);
      end else begin
        dir   = DIR_BRAKE;
        o     = 0;
        integ = 0;
      end

      if (o > 0) begin
        dir = DIR_CW;
        lvl = LVL_W'(o);
      end else if (o < 0) begin
        dir = DIR_CCW;
        lvl = LVL_W'(-o);
      end
      last_co = int'(o);
    end
    w.level = lvl;
    w.dir   = dir;
    w.co    = CO_W'(last_co);
    return w;
  endfunction

  always @(posedge clk) begin : watch
    drive_word_t want;
    if (!rst_n) begin
      ramp_on  = RST_RAMP_MODE;
      sp       = RST_SETPOINT;
      spd      = RST_SPEED;
      kp       = RST_KP;
      ki       = RST_KI;
      kd       = RST_KD;
      sb       = RST_STOP_BAND;
      md       = RST_MIN_DRIVE;
      ref_fx   = '0;
      integ    = 0;
      prev_err = 0;
      lvl      = '0;
      dir      = DIR_BRAKE;
      last_co  = 0;
      drive_due.delete();
    end else begin
      if (out_word.valid && out_word.ready) begin
        if (drive_due.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = drive_due.pop_front();
          if (out_word.drive_level !== want.level)
            report_mismatch($sformatf("drive_level %0d, expected %0d",
                                      out_word.drive_level, want.level));
          if (out_word.direction !== want.dir)
            report_mismatch($sformatf("direction %0d, expected %0d",
                                      out_word.direction, want.dir));
          if (out_word.control_out !== want.co)
            report_mismatch($sformatf("control_out %0d, expected %0d",
                                      out_word.control_out, $signed(want.co)));
        end
        words_out++;
      end
      if (in_word.valid && in_word.ready)
        drive_due.push_back(advance_drive(in_word.angle, in_word.enable));
      if (cfg_we) begin
        case (cfg_index)
          REG_RAMP_MODE:  ramp_on = cfg_data[0];
          REG_SETPOINT:   sp      = cfg_data[ANG_W-1:0];
          REG_RAMP_SPEED: spd     = cfg_data[SPD_W-1:0];
          REG_KP_GAIN:    kp      = cfg_data[GAIN_W-1:0];
          REG_KI_GAIN:    ki      = cfg_data[GAIN_W-1:0];
          REG_KD_GAIN:    kd      = cfg_data[GAIN_W-1:0];
          REG_STOP_BAND:  sb      = cfg_data[SB_W-1:0];
          REG_MIN_DRIVE:  md      = cfg_data[LVL_W-1:0];
          default: ;
        endcase
      end
    end
    waiting = drive_due.size();
  end

endmodule

@@ tb/sv/angle_pid_motor_drive_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the angle PID drive: clock, reset, stimulus and verdict.
module angle_pid_motor_drive_test;
  import apmd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PAST_END = CFG_IDX_W'(REG_MIN_DRIVE) + 1'b1;

  typedef struct {
    logic              ramp_mode;
    logic [ANG_W-1:0]  setpoint;
    logic [SPD_W-1:0]  speed;
    logic [GAIN_W-1:0] kp, ki, kd;
    logic [SB_W-1:0]   stop_band;
    logic [LVL_W-1:0]  min_drive;
  } drive_cfg_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;
  int                    cycle_count = 0;
  bit                    idle_on = 1'b1;
  bit                    stall_on = 1'b1;

  apmd_in_if  in_word();
  apmd_out_if out_word();

  angle_pid_motor_drive dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .out_word  (out_word)
  );

  angle_pid_motor_drive_checker drive_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_word    (in_word),
    .out_word   (out_word),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  always @(negedge clk) out_word.ready <= !(stall_on && $urandom_range(99) < 8);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL angle_pid_motor_drive");
      $finish;
    end
  end

  task automatic send_sample(input logic [ANG_W-1:0] a, input logic en);
    while (idle_on && $urandom_range(99) < 8) begin
      in_word.valid <= 1'b0;
      @(negedge clk);
    end
    in_word.valid  <= 1'b1;
    in_word.angle  <= a;
    in_word.enable <= en;
    do @(posedge clk); while (!in_word.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_word.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
  endtask

  task automatic apply_settings(input drive_cfg_t c);
    set_reg(REG_RAMP_MODE, CFG_DATA_W'(c.ramp_mode));
    set_reg(REG_SETPOINT, CFG_DATA_W'(c.setpoint));
    set_reg(REG_RAMP_SPEED, CFG_DATA_W'(c.speed));
    set_reg(REG_KP_GAIN, c.kp);
    set_reg(REG_KI_GAIN, c.ki);
    set_reg(REG_KD_GAIN, c.kd);
    set_reg(REG_STOP_BAND, CFG_DATA_W'(c.stop_band));
    set_reg(REG_MIN_DRIVE, CFG_DATA_W'(c.min_drive));
    // unmapped index, must be ignored
    set_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_PAST_END)),
            CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(2047));
    endcase
  endfunction

  initial begin
    drive_cfg_t       c;
    bit               windup;
    int               aim;
    int               a;
    int               count;
    logic [ANG_W-1:0] ang;
    logic             en;

    in_word.valid  = 1'b0;
    in_word.angle  = '0;
    in_word.enable = 1'b0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: step mode, setpoint 90 deg
    send_sample(13'd1440, 1'b1);
    send_sample(13'd1456, 1'b1);
    send_sample(13'd1457, 1'b1);
    send_sample(13'd0, 1'b1);
    send_sample(13'd5759, 1'b1);
    send_sample(13'd0, 1'b0);
    send_sample(13'd4320, 1'b1);
    send_sample(13'd4321, 1'b1);
    send_sample(13'd8191, 1'b1);
    send_sample(13'd5760, 1'b1);
    send_sample(13'd1440, 1'b0);
    send_sample(13'd1440, 1'b1);

    // saturated setpoint, max gains, min drive over the limit
    wait_drained();
    apply_settings('{ramp_mode: 1'b1, setpoint: '1, speed: '1, kp: '1, ki: '1, kd: '1,
                     stop_band: '0, min_drive: '1});
    send_sample(13'd0, 1'b1);
    send_sample(13'd8191, 1'b1);
    send_sample(13'd0, 1'b0);
    send_sample(13'd5759, 1'b1);

    // setpoint below the ramped reference, everything in the stop band
    wait_drained();
    apply_settings('{ramp_mode: 1'b1, setpoint: '0, speed: '0, kp: '0, ki: '0, kd: '0,
                     stop_band: '1, min_drive: '0});
    send_sample(13'd0, 1'b1);
    send_sample(13'd2000, 1'b1);
    send_sample(13'd8191, 1'b1);

    // zero control sum outside the stop band, raised to the minimum drive
    wait_drained();
    apply_settings('{ramp_mode: 1'b0, setpoint: 13'd2880, speed: 7'd100, kp: '0, ki: '0,
                     kd: '0, stop_band: '0, min_drive: 10'd500});
    send_sample(13'd0, 1'b1);
    send_sample(13'd2881, 1'b1);

    for (int p = 0; p < 10; p++) begin
      windup   = (p == 2 || p == 7);
      idle_on  = (p != 4);
      stall_on = (p != 4);

      c.ramp_mode = 1'($urandom);
      case ($urandom_range(9))
        0:       c.setpoint = '1;
        1:       c.setpoint = '0;
        2:       c.setpoint = ANG_W'(FULL_TURN);
        default: c.setpoint = ANG_W'($urandom_range(FULL_TURN));
      endcase
      case ($urandom_range(3))
        0:       c.speed = '0;
        1:       c.speed = '1;
        2:       c.speed = SPD_W'(100);
        default: c.speed = SPD_W'($urandom);
      endcase
      c.kp = pick_gain();
      c.ki = pick_gain();
      c.kd = pick_gain();
      case ($urandom_range(4))
        0:       c.stop_band = '0;
        1:       c.stop_band = '1;
        2:       c.stop_band = SB_W'($urandom);
        default: c.stop_band = SB_W'($urandom_range(64));
      endcase
      case ($urandom_range(4))
        0:       c.min_drive = '0;
        1:       c.min_drive = '1;
        2:       c.min_drive = LVL_W'($urandom);
        default: c.min_drive = LVL_W'($urandom_range(200));
      endcase
      if (windup) begin
        c.ramp_mode = 1'b0;
        c.stop_band = SB_W'($urandom_range(64));
      end

      wait_drained();
      apply_settings(c);

      aim = ((c.setpoint > FULL_TURN) ? FULL_TURN : int'(c.setpoint)) % FULL_TURN;
      if (windup) aim = (aim + $urandom_range(2840, 2600)) % FULL_TURN;
      count = windup ? 360 : 60;

      for (int i = 0; i < count; i++) begin
        a = aim + $urandom_range(64) - 32;
        if (windup) begin
          if ($urandom_range(19) == 0) a = $urandom_range(8191);
        end else begin
          case ($urandom_range(9))
            0: a = $urandom_range(8191);
            1: a = $urandom_range(FULL_TURN - 1);
            2: begin
              case ($urandom_range(3))
                0:       a = 0;
                1:       a = FULL_TURN - 1;
                2:       a = FULL_TURN;
                default: a = 8191;
              endcase
            end
            3, 4: a = aim + $urandom_range(400) - 200;
            default: ;
          endcase
        end
        if (a < 0) a += FULL_TURN;
        if (a >= 8192) a -= FULL_TURN;
        ang = ANG_W'(a);
        en  = ($urandom_range(99) >= (windup ? 3 : 10));
        send_sample(ang, en);
      end
    end

    idle_on  = 1'b1;
    stall_on = 1'b1;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS angle_pid_motor_drive");
    end else begin
      $display("FAIL angle_pid_motor_drive");
    end
    $finish;
  end

endmodule
